FILE: hw/rtl/pnu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygonal number unit package
// Shared constants, transfer types and the per-stage step functions of the
// square root and divider pipelines.
// ----------------------------------------------------------------------------
package pnu_pkg;

   localparam int VAL_W  = 63;            // operand and result width
   localparam int SIDE_W = 8;             // side count width
   localparam int DSQ_W  = 16;            // width of (s-4)^2
   localparam int DISC_W = 76;            // discriminant width
   localparam int ROOT_W = DISC_W / 2;    // integer square root width
   localparam int REM_W  = ROOT_W + 2;    // square root remainder width
   localparam int NUM_W  = ROOT_W + 1;    // dividend width, r + s - 4
   localparam int DEN_W  = 9;             // divisor width, 2s - 4

   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;
   localparam logic ST_OK      = 1'b0;
   localparam logic ST_REJECT  = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [VAL_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] result;
      logic             status;
   } rsp_type;

   // Item leaving the multiplier front end.
   typedef struct packed {
      logic              op;
      logic              vzero;
      logic [VAL_W-1:0]  fres;
      logic [DISC_W-1:0] disc;
   } front_type;

   // Item inside the square root pipeline.
   typedef struct packed {
      logic              op;
      logic              vzero;
      logic [VAL_W-1:0]  fres;
      logic [DISC_W-1:0] disc;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_type;

   // Item inside the divider pipeline. The dividend register fills with the
   // quotient from the bottom as its bits are consumed from the top.
   typedef struct packed {
      logic             op;
      logic             vzero;
      logic [VAL_W-1:0] fres;
      logic             exact;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] rem;
   } div_type;

   // One digit of the restoring square root: two discriminant bits in,
   // one root bit out.
   function automatic root_type root_step(root_type x);
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      logic             take;
      root_type         y;
      y     = x;
      acc   = {x.rem, x.disc[DISC_W-1 -: 2]};
      trial = {2'b00, x.root, 2'b01};
      take  = (acc >= trial);
      if (take) begin
         y.rem = REM_W'(acc - trial);
      end else begin
         y.rem = acc[REM_W-1:0];
      end
      y.root = {x.root[ROOT_W-2:0], take};
      y.disc = x.disc << 2;
      return y;
   endfunction

   // One quotient bit of a restoring division by den.
   function automatic div_type div_step(div_type x, logic [DEN_W-1:0] den);
      logic [DEN_W:0] acc;
      logic           take;
      div_type        y;
      y    = x;
      acc  = {x.rem, x.num[NUM_W-1]};
      take = (acc >= {1'b0, den});
      if (take) begin
         y.rem = DEN_W'(acc - {1'b0, den});
      end else begin
         y.rem = acc[DEN_W-1:0];
      end
      y.num = {x.num[NUM_W-2:0], take};
      return y;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pnu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygonal number unit front end
// Three multiplier stages: the forward value P(s,n) with saturation, and the
// discriminant 8(s-2)v + (s-4)^2 for the inverse path.
// ----------------------------------------------------------------------------
module pnu_front #(
   parameter int INDEX_BITS = 28
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire pnu_pkg::req_type         in_data,
   input  wire logic [pnu_pkg::SIDE_W-1:0] sm2,
   input  wire logic [pnu_pkg::DSQ_W-1:0]  dsq,
   output logic                          out_valid,
   output pnu_pkg::front_type            out_data
);
   import pnu_pkg::*;

   localparam int T_W = INDEX_BITS + SIDE_W + 1;
   localparam int TL  = (T_W + 1) / 2;
   localparam int TH  = T_W - TL;
   localparam int P_W = INDEX_BITS + T_W;
   localparam int PX  = (P_W > 65) ? P_W : 65;

   // Stage 1
   logic                      v1_ff;
   logic                      op1_ff, vz1_ff;
   logic [INDEX_BITS-1:0]     n1_ff;
   logic [T_W-1:0]            t1_ff, t1_in;
   logic [42:0]               pl1_ff, pl1_in;
   logic [41:0]               ph1_ff, ph1_in;
   logic [INDEX_BITS-1:0]     nm1;
   logic [INDEX_BITS+SIDE_W-1:0] tm;
   logic [SIDE_W+2:0]         k;

   // Stage 2
   logic                      v2_ff;
   logic                      op2_ff, vz2_ff;
   logic [INDEX_BITS+TL-1:0]  plo2_ff;
   logic [INDEX_BITS+TH-1:0]  phi2_ff;
   logic [DISC_W-1:0]         disc2_ff;

   // Stage 3
   logic                      v3_ff;
   front_type                 f3_ff;
   logic [PX-1:0]             p;

   always_comb begin
      nm1    = in_data.operand[INDEX_BITS-1:0] - INDEX_BITS'(1);
      tm     = sm2 * nm1;
      t1_in  = {1'b0, tm} + T_W'(2);
      k      = {sm2, 3'b000};
      pl1_in = k * in_data.operand[31:0];
      ph1_in = k * in_data.operand[62:32];
      p      = PX'(plo2_ff) + (PX'(phi2_ff) << TL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff   <= in_data.opcode;
         vz1_ff   <= (in_data.operand == '0);
         n1_ff    <= in_data.operand[INDEX_BITS-1:0];
         t1_ff    <= t1_in;
         pl1_ff   <= pl1_in;
         ph1_ff   <= ph1_in;

         op2_ff   <= op1_ff;
         vz2_ff   <= vz1_ff;
         plo2_ff  <= n1_ff * t1_ff[TL-1:0];
         phi2_ff  <= n1_ff * t1_ff[T_W-1:TL];
         disc2_ff <= DISC_W'({ph1_ff, 32'd0}) + DISC_W'(pl1_ff) + DISC_W'(dsq);

         f3_ff.op    <= op2_ff;
         f3_ff.vzero <= vz2_ff;
         f3_ff.disc  <= disc2_ff;
         f3_ff.fres  <= (|p[PX-1:64]) ? {VAL_W{1'b1}} : p[63:1];
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = f3_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/polygonal_number_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygonal number unit
// Forward s-gonal numbers and exact inverse test for a configured side count.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req_ channel as a valid/ready transfer with an
// opcode and a 63-bit operand. Opcode forward returns P(s,n) for the low
// INDEX_BITS bits of the operand, saturated to all ones on overflow. Opcode
// inverse returns the index n of an s-gonal value, or status reject and a
// zero result when the value is not s-gonal. Every request gives exactly one
// response on the rsp_ channel, in request order.
// The side count is written through csr_wr_en/csr_wr_data while the unit is
// idle; values below three are ignored. Reset sets it to three.
// Throughput is one transfer per cycle while the receiver does not stall.
// A request passes three multiplier stages, 38 square root stages (one root
// bit each), one stage forming the dividend, 39 divider stages (one quotient
// bit each) and the output register on its way to the response.
// A synchronous reset empties the pipeline. When the receiver stalls, one more
// result lands in a skid register and then the whole pipeline holds;
// req_ready depends only on that skid register.
// ----------------------------------------------------------------------------
module polygonal_number_unit #(
   parameter int INDEX_BITS = 28
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire pnu_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output pnu_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [pnu_pkg::SIDE_W-1:0]  csr_wr_data
);
   import pnu_pkg::*;

   // Side-count derived values, kept precomputed so the datapath sees
   // registers only: s-2, (s-4)^2 and 2s-4.
   logic [SIDE_W-1:0] sm2_ff;
   logic [DSQ_W-1:0]  dsq_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [SIDE_W-1:0] d4;

   always_comb begin
      d4 = (csr_wr_data >= SIDE_W'(4)) ? (csr_wr_data - SIDE_W'(4))
                                       : (SIDE_W'(4) - csr_wr_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm2_ff <= SIDE_W'(1);
         dsq_ff <= DSQ_W'(1);
         den_ff <= DEN_W'(2);
      end else if (csr_wr_en && (csr_wr_data >= SIDE_W'(3))) begin
         sm2_ff <= csr_wr_data - SIDE_W'(2);
         dsq_ff <= d4 * d4;
         den_ff <= {csr_wr_data, 1'b0} - DEN_W'(4);
      end
   end

   // The pipeline advances as long as the skid register is empty.
   logic en;
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req_ready = en;

   logic      front_v;
   front_type front_d;

   pnu_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .sm2       (sm2_ff),
      .dsq       (dsq_ff),
      .out_valid (front_v),
      .out_data  (front_d)
   );

   // Square root pipeline, one root bit per stage.
   root_type          r_ff [ROOT_W];
   logic [ROOT_W-1:0] rv_ff;
   root_type          r_init;

   always_comb begin
      r_init.op    = front_d.op;
      r_init.vzero = front_d.vzero;
      r_init.fres  = front_d.fres;
      r_init.disc  = front_d.disc;
      r_init.rem   = '0;
      r_init.root  = '0;
   end

   // Divider pipeline: the first stage forms r + s - 4, then one quotient
   // bit per stage.
   div_type          d_ff [NUM_W+1];
   logic [NUM_W:0]   dv_ff;
   div_type          d_init;

   always_comb begin
      d_init.op    = r_ff[ROOT_W-1].op;
      d_init.vzero = r_ff[ROOT_W-1].vzero;
      d_init.fres  = r_ff[ROOT_W-1].fres;
      d_init.exact = (r_ff[ROOT_W-1].rem == '0);
      d_init.num   = NUM_W'(r_ff[ROOT_W-1].root) + NUM_W'(sm2_ff) - NUM_W'(2);
      d_init.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
         dv_ff <= '0;
      end else if (en) begin
         rv_ff <= {rv_ff[ROOT_W-2:0], front_v};
         dv_ff <= {dv_ff[NUM_W-1:0], rv_ff[ROOT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= root_step(r_init);
         for (int i = 1; i < ROOT_W; i++) begin
            r_ff[i] <= root_step(r_ff[i-1]);
         end
         d_ff[0] <= d_init;
         for (int j = 1; j <= NUM_W; j++) begin
            d_ff[j] <= div_step(d_ff[j-1], den_ff);
         end
      end
   end

   // Result assembly from the last divider stage.
   rsp_type last_rsp;
   div_type last_d;

   always_comb begin
      last_d = d_ff[NUM_W];
      if (last_d.op == OP_FORWARD) begin
         last_rsp.result = last_d.fres;
         last_rsp.status = ST_OK;
      end else if (last_d.vzero) begin
         last_rsp.result = '0;
         last_rsp.status = ST_OK;
      end else if (last_d.exact && (last_d.rem == '0)) begin
         last_rsp.result = VAL_W'(last_d.num);
         last_rsp.status = ST_OK;
      end else begin
         last_rsp.result = '0;
         last_rsp.status = ST_REJECT;
      end
   end

   // Output register with a skid register behind it.
   logic    out_v_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    take;
   logic    last_v;

   assign take   = out_v_ff && rsp_ready;
   assign last_v = dv_ff[NUM_W] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= last_v;
         end
      end else if (last_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take || !out_v_ff) begin
         out_ff <= skid_v_ff ? skid_ff : last_rsp;
      end else if (last_v) begin
         skid_ff <= last_rsp;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // The skid register only fills behind a waiting output.
   assert property (@(posedge clock) disable iff (reset) skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register is empty");

   // A held skid entry stays until the output is taken.
   assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_ready) |=> skid_v_ff)
      else $error("skid entry lost during a stall");

   // A rejected value always reports a zero result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_REJECT)) |-> (rsp_data.result == '0))
      else $error("rejected response carries a nonzero result");

endmodule
`default_nettype wire
